### rtl/text_attribute_gray_contrast_map_assert.svh
// Assertion macros for the text attribute grey contrast map.
`ifndef TEXT_ATTRIBUTE_GRAY_CONTRAST_MAP_ASSERT_SVH
`define TEXT_ATTRIBUTE_GRAY_CONTRAST_MAP_ASSERT_SVH

// Checked property, skipped while reset is high.
`define TAGCM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tagcm assertion failed");

// Checked property, also during reset.
`define TAGCM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tagcm assertion failed");

`endif

### rtl/tagcm_pkg.sv
// Package: shared types and constants of the text attribute grey contrast map.
package tagcm_pkg;

  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned ATTR_W     = 8;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned REG_DATA_W = 8;

  localparam logic [7:0] SHIFT_ALL   = 8'hFF;
  localparam logic [7:0] SHADE_BLUE  = 8'h70;
  localparam logic [3:0] GREEN_OFS   = 4'h8;
  localparam logic [3:0] LEVEL_MAX   = 4'hF;
  localparam logic [3:0] LEVEL_MIN   = 4'h0;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SHIFT     = 2'd1,
    REG_INVERT    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [3:0] threshold;
    logic       sat;
    logic       four;
    logic [3:0] back_step;
    logic [3:0] fore_step;
    logic       noinv;
  } cfg_t;

endpackage

### rtl/tagcm_cfg_regs.sv
// Configuration register file: threshold, shift and display invert bits.
module tagcm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [tagcm_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [tagcm_pkg::REG_DATA_W-1:0] wr_data,
  output tagcm_pkg::cfg_t                  cfg
);
  import tagcm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_THRESHOLD: begin
          cfg.threshold <= wr_data[3:0];
          cfg.sat       <= wr_data[4];
          cfg.four      <= wr_data[5];
        end
        REG_SHIFT: begin
          cfg.fore_step <= wr_data[3:0];
          cfg.back_step <= wr_data[7:4];
        end
        REG_INVERT: begin
          cfg.noinv <= wr_data[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/tagcm_contrast.sv
// Contrast stage: IRGB to RGBI reorder and closeness-driven level stretch.
module tagcm_contrast (
  input  logic [tagcm_pkg::ATTR_W-1:0]  attribute,
  input  tagcm_pkg::cfg_t               cfg,
  output logic [tagcm_pkg::LEVEL_W-1:0] back_level,
  output logic [tagcm_pkg::LEVEL_W-1:0] fore_level
);
  import tagcm_pkg::*;

  function automatic logic [3:0] step_level(input logic [3:0] level, input logic [3:0] step,
                                            input logic up, input logic sat);
    logic [4:0] r;
    logic [3:0] res;
    r   = up ? ({1'b0, level} + {1'b0, step}) : ({1'b0, level} - {1'b0, step});
    res = r[3:0];
    // bit 4 flags carry on the way up, borrow on the way down
    if (sat && r[4]) res = up ? LEVEL_MAX : LEVEL_MIN;
    return res;
  endfunction

  logic [3:0] bg, fg, diff;
  logic       close, fg_hi, equal;

  assign bg    = {attribute[6:4], attribute[7]};
  assign fg    = {attribute[2:0], attribute[3]};
  assign fg_hi = fg > bg;
  assign equal = fg == bg;
  assign diff  = fg_hi ? (fg - bg) : (bg - fg);
  assign close = diff <= cfg.threshold;

  always_comb begin
    back_level = bg;
    fore_level = fg;
    if (close) begin
      if (equal) begin
        if ({cfg.back_step, cfg.fore_step} == SHIFT_ALL) begin
          fore_level = fg[3] ? LEVEL_MAX : LEVEL_MIN;
          back_level = fore_level;
        end
      end else begin
        fore_level = step_level(fg, cfg.fore_step, fg_hi, cfg.sat);
        back_level = step_level(bg, cfg.back_step, !fg_hi, cfg.sat);
      end
    end
  end

endmodule

### rtl/tagcm_shade.sv
// Grey shade: maps one RGBI level to a packed 24-bit grey colour.
module tagcm_shade (
  input  logic [tagcm_pkg::LEVEL_W-1:0] level,
  input  tagcm_pkg::cfg_t               cfg,
  output logic [tagcm_pkg::COLOR_W-1:0] color
);
  import tagcm_pkg::*;

  logic [3:0] lv;
  logic [2:0] q4;
  logic [3:0] q8;
  logic [7:0] red;

  assign lv  = cfg.noinv ? level : ~level;   // ~L == 15 - L on four bits
  assign q4  = {1'b0, lv[3:2]} + 3'd2;
  assign q8  = {1'b0, lv[3:1]} + 4'd2;
  assign red = cfg.four ? {q4, 5'b0} : {q8, 4'b0};
  // low nibble of red is zero, so +8 is a plain OR
  assign color = {red, red[7:4], GREEN_OFS, SHADE_BLUE};

endmodule

### rtl/text_attribute_gray_contrast_map.sv
// Top level: text attribute grey contrast map with input and result registers.
//
// Usage:
//   Input channel: attribute with in_valid / in_stall. A request is taken at a
//   rising edge with in_valid high and in_stall low.
//   Output channel: back_level, fore_level, back_color, fore_color with
//   out_valid / out_stall, taken at an edge with out_valid high, out_stall low.
//   Config: wr_en, wr_index, wr_data; index 0 threshold, 1 shift, 2 invert.
//   Write config only while no request is in flight.
// Pipeline: an accepted request passes the input register, then the result
//   register (two register stages) on its way to the outputs.
// Throughput: one request per cycle while out_stall is low; the logic between
//   registers is compares, a difference, two 4-bit add/subtracts and shading.
// Stall: the result register holds while out_valid and out_stall are high;
//   the input register still fills, so in_stall rises only when both are full.
// Reset: rst (synchronous) empties both stages and clears all config
//   registers to zero.
module text_attribute_gray_contrast_map (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tagcm_pkg::ATTR_W-1:0]      attribute,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tagcm_pkg::LEVEL_W-1:0]     back_level,
  output logic [tagcm_pkg::LEVEL_W-1:0]     fore_level,
  output logic [tagcm_pkg::COLOR_W-1:0]     back_color,
  output logic [tagcm_pkg::COLOR_W-1:0]     fore_color,
  input  logic                              wr_en,
  input  logic [tagcm_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [tagcm_pkg::REG_DATA_W-1:0]  wr_data
);
  import tagcm_pkg::*;

  cfg_t               cfg;
  logic               s1_valid;
  logic [ATTR_W-1:0]  s1_attr;
  logic               out_load;
  logic [LEVEL_W-1:0] back_level_next, fore_level_next;
  logic [COLOR_W-1:0] back_color_next, fore_color_next;

  tagcm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  tagcm_contrast u_contrast (
    .attribute  (s1_attr),
    .cfg        (cfg),
    .back_level (back_level_next),
    .fore_level (fore_level_next)
  );

  tagcm_shade u_shade_back (
    .level (back_level_next),
    .cfg   (cfg),
    .color (back_color_next)
  );

  tagcm_shade u_shade_fore (
    .level (fore_level_next),
    .cfg   (cfg),
    .color (fore_color_next)
  );

  assign out_load = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_attr <= attribute;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      back_level <= back_level_next;
      fore_level <= fore_level_next;
      back_color <= back_color_next;
      fore_color <= fore_color_next;
    end
  end

endmodule

### rtl/tagcm_checker.sv
// Port-level checker for the text attribute grey contrast map, with its bind.
`include "text_attribute_gray_contrast_map_assert.svh"

module tagcm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [tagcm_pkg::COLOR_W-1:0]     back_color,
  input logic [tagcm_pkg::COLOR_W-1:0]     fore_color
);

  logic back_grey, fore_grey;

  // green 8 above red, fixed blue
  assign back_grey = back_color[15:0] == {back_color[23:16] + 8'h08, 8'h70};
  assign fore_grey = fore_color[15:0] == {fore_color[23:16] + 8'h08, 8'h70};

  // result held while the receiver stalls
  `TAGCM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
  // reset empties the result register
  `TAGCM_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid)
  // back-pressure only reaches the input once the output is stalled
  `TAGCM_ASSERT(a_stall_src, in_stall |-> out_valid && out_stall)
  // an accepted request reaches the output when out_stall is low while it sits in the input register
  `TAGCM_ASSERT(a_latency, (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
  // grey shade on both colors
  `TAGCM_ASSERT(a_grey, out_valid |-> back_grey && fore_grey)

endmodule

bind text_attribute_gray_contrast_map tagcm_checker u_tagcm_checker (.*);
